@@ rtl/mtce_pkg.sv @@
// Package for the masked token cross-entropy unit.
// Holds the widths, constants, record and result types and the back-end state type.
// No dependencies.
package mtce_pkg;

  localparam int unsigned VocabW    = 17;
  localparam int unsigned ProbW     = 17;
  localparam int unsigned ClassW    = 16;
  localparam int unsigned MeanW     = 20;
  localparam int unsigned CountW    = 21;
  localparam int unsigned SumW      = 41;
  localparam int unsigned LogFrac   = 28;
  localparam int unsigned ProbFrac  = 16;

  localparam logic [VocabW-1:0] VocabMin   = 17'd2;
  localparam logic [VocabW-1:0] VocabMax   = 17'd65536;
  localparam logic [CountW-1:0] MaxTokens  = 21'd1048576;
  localparam logic [MeanW-1:0]  MeanMax    = 20'd786431;
  localparam logic [31:0]       Ln2Q32     = 32'd2977044472;
  // Fraction bits of the probability, placed at the log2 binary point.
  localparam logic [32:0]       LogLimit   = 33'(ProbFrac) << LogFrac;

  // One finished token row, as handed from the front end to the back end.
  typedef struct packed {
    logic             tgt_ok;   // target in 1..V-1
    logic             correct;  // argmax equals target
    logic             hit;      // target column was reached
    logic [ProbW-1:0] prob;     // probability at the target column
    logic             last;     // row closes the batch
  } rec_t;

  typedef struct packed {
    logic [MeanW-1:0]  mean_loss;
    logic [CountW-1:0] num_active;
    logic [CountW-1:0] num_correct;
  } result_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_LOG,
    ST_MUL,
    ST_ACC,
    ST_DSTART,
    ST_DIV,
    ST_EMIT
  } back_state_e;

endpackage

@@ rtl/mtce_if.sv @@
// Channel interfaces of the masked token cross-entropy unit.
// Depends on nothing; widths follow the package constants by value.
interface mtce_in_if;
  logic        valid;
  logic        ready;
  logic [16:0] probability;
  logic [15:0] target_class;
  logic        last_of_batch;

  modport source (output valid, probability, target_class, last_of_batch, input ready);
  modport sink   (input valid, probability, target_class, last_of_batch, output ready);
endinterface

interface mtce_out_if;
  logic        valid;
  logic        ready;
  logic [19:0] mean_loss;
  logic [20:0] num_active;
  logic [20:0] num_correct;

  modport source (output valid, mean_loss, num_active, num_correct, input ready);
  modport sink   (input valid, mean_loss, num_active, num_correct, output ready);
endinterface

@@ rtl/masked_token_cross_entropy_unit.sv @@
// Masked token cross-entropy unit: the front end takes one probability word per cycle
// while the queue has room. Each finished row waits in a short queue; an active row with a
// reached target costs the back end 28 squaring steps on a 32x32 squarer, other rows skip
// the log, so short rows fill the queue and then stall the input. Once a batch's last row
// leaves the queue, its result waits on that row's log if needed and the 41-step divider.
// Reset (asynchronous, active low) clears counters, queue and result valid; vocab is 65536.
module masked_token_cross_entropy_unit #(
  parameter int unsigned FIFO_DEPTH = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [16:0] cfg_wdata_i,
  mtce_in_if.sink     in_i,
  mtce_out_if.source  out_o
);

  // Vocabulary size, clamped into 2..65536 when it is written.
  logic [mtce_pkg::VocabW-1:0] vocab_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vocab_q <= mtce_pkg::VocabMax;
    end else if (cfg_we_i) begin
      if (cfg_wdata_i < mtce_pkg::VocabMin) begin
        vocab_q <= mtce_pkg::VocabMin;
      end else if (cfg_wdata_i > mtce_pkg::VocabMax) begin
        vocab_q <= mtce_pkg::VocabMax;
      end else begin
        vocab_q <= cfg_wdata_i;
      end
    end
  end

  logic              push, pop, full, empty;
  mtce_pkg::rec_t    wrec, rrec;
  mtce_pkg::result_t res;

  // The front end finishes one row record per row end and stalls only on a full queue.
  mtce_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .vocab_i (vocab_q),
    .in_i    (in_i),
    .full_i  (full),
    .push_o  (push),
    .rec_o   (wrec)
  );

  mtce_fifo #(.DEPTH(FIFO_DEPTH)) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (wrec),
    .pop_i   (pop),
    .rdata_o (rrec),
    .full_o  (full),
    .empty_o (empty)
  );

  // The back end owns the batch sums and the result register, so a pending result
  // does not block rows of the next batch until that batch also ends.
  mtce_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .empty_i     (empty),
    .rec_i       (rrec),
    .pop_o       (pop),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .out_o       (res)
  );

  assign out_o.mean_loss   = res.mean_loss;
  assign out_o.num_active  = res.num_active;
  assign out_o.num_correct = res.num_correct;

endmodule

@@ rtl/mtce_front.sv @@
// Front end: accepts one probability word a cycle unless the queue is full; counts columns, tracks argmax and target.
// Depends on mtce_pkg and mtce_in_if.
module mtce_front (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic [mtce_pkg::VocabW-1:0] vocab_i,
  mtce_in_if.sink                    in_i,
  input  logic                       full_i,
  output logic                       push_o,
  output mtce_pkg::rec_t             rec_o
);

  logic [mtce_pkg::ClassW-1:0] col_q, col_d;
  logic [mtce_pkg::ClassW-1:0] tgt_q, tgt_d;
  logic [mtce_pkg::ProbW-1:0]  max_q, max_d;
  logic [mtce_pkg::ClassW-1:0] best_q, best_d;
  logic                        hit_q, hit_d;
  logic [mtce_pkg::ProbW-1:0]  hprob_q, hprob_d;
  logic                        accept;
  logic                        first;
  logic                        row_end;
  logic [mtce_pkg::ClassW-1:0] tgt;

  assign in_i.ready = !full_i;
  assign accept     = in_i.valid && !full_i;
  assign first      = (col_q == '0);
  assign tgt        = first ? in_i.target_class : tgt_q;
  assign row_end    = ({1'b0, col_q} >= (vocab_i - 17'd1)) || in_i.last_of_batch;

  always_comb begin
    max_d   = first ? in_i.probability : max_q;
    best_d  = first ? '0 : best_q;
    if (!first && (in_i.probability > max_q)) begin
      max_d  = in_i.probability;
      best_d = col_q;
    end
    hit_d   = first ? 1'b0 : hit_q;
    hprob_d = hprob_q;
    if (col_q == tgt) begin
      hit_d   = 1'b1;
      hprob_d = in_i.probability;
    end
    tgt_d = tgt;
    col_d = row_end ? '0 : col_q + 16'd1;
  end

  assign push_o        = accept && row_end;
  assign rec_o.tgt_ok  = (tgt != '0) && ({1'b0, tgt} < vocab_i);
  assign rec_o.correct = (best_d == tgt);
  assign rec_o.hit     = hit_d;
  assign rec_o.prob    = hprob_d;
  assign rec_o.last    = in_i.last_of_batch;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      hit_q <= 1'b0;
    end else if (accept) begin
      col_q <= col_d;
      hit_q <= hit_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      tgt_q   <= tgt_d;
      max_q   <= max_d;
      best_q  <= best_d;
      hprob_q <= hprob_d;
    end
  end

endmodule

@@ rtl/mtce_fifo.sv @@
// Short row-record queue between the front end and the back end.
// Depends on mtce_pkg.
module mtce_fifo #(
  parameter int unsigned DEPTH = 4
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  mtce_pkg::rec_t wdata_i,
  input  logic           pop_i,
  output mtce_pkg::rec_t rdata_o,
  output logic           full_o,
  output logic           empty_o
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  mtce_pkg::rec_t mem_q [DEPTH];
  logic [AW-1:0]  wptr_q, rptr_q;
  logic [CW-1:0]  cnt_q;
  logic           do_push, do_pop;

  assign full_o  = (cnt_q == CW'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = mem_q[rptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (do_push) begin
        wptr_q <= (wptr_q == AW'(DEPTH - 1)) ? '0 : wptr_q + AW'(1);
      end
      if (do_pop) begin
        rptr_q <= (rptr_q == AW'(DEPTH - 1)) ? '0 : rptr_q + AW'(1);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + CW'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - CW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= wdata_i;
    end
  end

endmodule

@@ rtl/mtce_back.sv @@
// Back end: per-row loss via log2 by repeated squaring, batch sums, mean by restoring division.
// Depends on mtce_pkg.
module mtce_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              empty_i,
  input  mtce_pkg::rec_t    rec_i,
  output logic              pop_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output mtce_pkg::result_t out_o
);

  mtce_pkg::back_state_e state_q, state_d;

  mtce_pkg::rec_t               rec_q, rec_d;
  logic [mtce_pkg::SumW-1:0]    sum_q, sum_d;
  logic [mtce_pkg::CountW-1:0]  act_q, act_d;
  logic [mtce_pkg::CountW-1:0]  cor_q, cor_d;
  logic [31:0]                  m_q, m_d;
  logic [4:0]                   k_q, k_d;
  logic [27:0]                  frac_q, frac_d;
  logic [5:0]                   cnt_q, cnt_d;
  logic [63:0]                  prod_q, prod_d;
  logic                         d32_q, d32_d;
  logic                         add_q, add_d;
  logic [mtce_pkg::CountW-1:0]  rem_q, rem_d;
  logic [mtce_pkg::SumW-1:0]    dq_q, dq_d;
  logic                         ov_q, ov_d;
  mtce_pkg::result_t            res_q, res_d;

  logic                         counted;
  logic [17:0]                  vplus;
  logic [4:0]                   kpos;
  logic [63:0]                  sq;
  logic [32:0]                  sq_hi;
  logic [32:0]                  lg;
  logic [32:0]                  dlt;
  logic [65:0]                  total;
  logic [21:0]                  rs;
  logic                         ge;
  logic                         out_free;

  assign counted  = rec_q.tgt_ok && (act_q < mtce_pkg::MaxTokens);
  assign vplus    = {1'b0, rec_q.prob} + 18'd1;
  assign sq       = 64'(m_q) * 64'(m_q);
  assign sq_hi    = sq[63:31];
  assign lg       = {k_q, frac_q};
  assign dlt      = mtce_pkg::LogLimit - lg;
  assign total    = {2'b0, prod_q} + (d32_q ? {2'b0, mtce_pkg::Ln2Q32, 32'd0} : 66'd0)
                    + (66'd1 << 43);
  assign rs       = {rem_q, dq_q[mtce_pkg::SumW-1]};
  assign ge       = (rs >= {1'b0, act_q});
  assign out_free = !ov_q || out_ready_i;

  // Position of the leading one of p+1.
  always_comb begin
    kpos = '0;
    for (int i = 0; i < 18; i++) begin
      if (vplus[i]) begin
        kpos = 5'(i);
      end
    end
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      mtce_pkg::ST_IDLE:   if (!empty_i) state_d = mtce_pkg::ST_LOAD;
      mtce_pkg::ST_LOAD:   state_d = (counted && rec_q.hit) ? mtce_pkg::ST_LOG
                                                            : mtce_pkg::ST_ACC;
      mtce_pkg::ST_LOG:    if (cnt_q == '0) state_d = mtce_pkg::ST_MUL;
      mtce_pkg::ST_MUL:    state_d = mtce_pkg::ST_ACC;
      mtce_pkg::ST_ACC:    state_d = rec_q.last ? mtce_pkg::ST_DSTART : mtce_pkg::ST_IDLE;
      mtce_pkg::ST_DSTART: state_d = (act_q == '0) ? mtce_pkg::ST_EMIT : mtce_pkg::ST_DIV;
      mtce_pkg::ST_DIV:    if (cnt_q == '0) state_d = mtce_pkg::ST_EMIT;
      mtce_pkg::ST_EMIT:   if (out_free) state_d = mtce_pkg::ST_IDLE;
      default:             state_d = mtce_pkg::ST_IDLE;
    endcase
  end

  // Datapath and outputs.
  always_comb begin
    pop_o  = 1'b0;
    rec_d  = rec_q;
    sum_d  = sum_q;
    act_d  = act_q;
    cor_d  = cor_q;
    m_d    = m_q;
    k_d    = k_q;
    frac_d = frac_q;
    cnt_d  = cnt_q;
    prod_d = prod_q;
    d32_d  = d32_q;
    add_d  = add_q;
    rem_d  = rem_q;
    dq_d   = dq_q;
    ov_d   = ov_q && !out_ready_i;
    res_d  = res_q;
    case (state_q)
      mtce_pkg::ST_IDLE: begin
        pop_o = !empty_i;
        rec_d = rec_i;
      end
      mtce_pkg::ST_LOAD: begin
        add_d = 1'b0;
        if (counted) begin
          act_d = act_q + 21'd1;
          cor_d = cor_q + 21'(rec_q.correct);
        end
        k_d    = kpos;
        m_d    = 32'(vplus) << (5'd31 - kpos);
        frac_d = '0;
        cnt_d  = 6'd27;
      end
      mtce_pkg::ST_LOG: begin
        if (sq_hi[32]) begin
          m_d = sq_hi[32:1];
        end else begin
          m_d = sq_hi[31:0];
        end
        frac_d = {frac_q[26:0], sq_hi[32]};
        cnt_d  = cnt_q - 6'd1;
      end
      mtce_pkg::ST_MUL: begin
        add_d  = (lg < mtce_pkg::LogLimit);
        prod_d = 64'(dlt[31:0]) * 64'(mtce_pkg::Ln2Q32);
        d32_d  = dlt[32];
      end
      mtce_pkg::ST_ACC: begin
        if (add_q) begin
          sum_d = sum_q + {21'd0, total[63:44]};
        end
      end
      mtce_pkg::ST_DSTART: begin
        rem_d = '0;
        dq_d  = (act_q == '0) ? '0 : sum_q;
        cnt_d = 6'd40;
      end
      mtce_pkg::ST_DIV: begin
        rem_d = ge ? 21'(rs - {1'b0, act_q}) : rs[20:0];
        dq_d  = {dq_q[mtce_pkg::SumW-2:0], ge};
        cnt_d = cnt_q - 6'd1;
      end
      mtce_pkg::ST_EMIT: begin
        if (out_free) begin
          ov_d              = 1'b1;
          res_d.mean_loss   = (dq_q > 41'(mtce_pkg::MeanMax)) ? mtce_pkg::MeanMax
                                                              : dq_q[19:0];
          res_d.num_active  = act_q;
          res_d.num_correct = cor_q;
          sum_d             = '0;
          act_d             = '0;
          cor_d             = '0;
        end
      end
      default: begin
        pop_o = 1'b0;
      end
    endcase
  end

  assign out_valid_o = ov_q;
  assign out_o       = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= mtce_pkg::ST_IDLE;
      sum_q   <= '0;
      act_q   <= '0;
      cor_q   <= '0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      sum_q   <= sum_d;
      act_q   <= act_d;
      cor_q   <= cor_d;
      ov_q    <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rec_q  <= rec_d;
    m_q    <= m_d;
    k_q    <= k_d;
    frac_q <= frac_d;
    cnt_q  <= cnt_d;
    prod_q <= prod_d;
    d32_q  <= d32_d;
    add_q  <= add_d;
    rem_q  <= rem_d;
    dq_q   <= dq_d;
    res_q  <= res_d;
  end

endmodule

@@ rtl/mtce_checker.sv @@
// Port-level checks for the masked token cross-entropy unit, bound to the top level.
// Depends on the top level's port names only.
module mtce_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [19:0] mean_loss_i,
  input logic [20:0] num_active_i,
  input logic [20:0] num_correct_i
);

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(mean_loss_i)
      && $stable(num_active_i) && $stable(num_correct_i))
    else $error("result word changed while stalled");

  a_correct_le_active: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> num_correct_i <= num_active_i)
    else $error("more correct tokens than active tokens");

  a_empty_mean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (num_active_i == 21'd0) |-> mean_loss_i == 20'd0)
    else $error("nonzero mean with no active tokens");

  a_mean_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> mean_loss_i <= 20'd786431)
    else $error("mean loss above saturation limit");

endmodule

bind masked_token_cross_entropy_unit mtce_checker u_mtce_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .out_valid_i   (out_o.valid),
  .out_ready_i   (out_o.ready),
  .mean_loss_i   (out_o.mean_loss),
  .num_active_i  (out_o.num_active),
  .num_correct_i (out_o.num_correct)
);
